/* sv/cq_pkg.sv */
`default_nettype none
package cq_pkg;

	// payload types
	typedef logic signed [31:0] word_t;
	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	// size register
	localparam int QSIZE_W = 5;
	typedef logic [QSIZE_W-1:0] qsize_t;
	localparam int QSIZE_RST = 16;
	localparam int QSIZE_MIN = 2;

	// commands
	localparam cmd_t CMD_ENQ        = 2'd0;
	localparam cmd_t CMD_DEQ        = 2'd1;
	localparam cmd_t CMD_PEEK_FRONT = 2'd2;
	localparam cmd_t CMD_PEEK_REAR  = 2'd3;

	// result status
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	localparam word_t WORD_NEG_ONE = -32'sd1;
	localparam word_t WORD_ZERO    = 32'sd0;

	// controller to datapath
	typedef struct packed {
		logic take;   // command word accepted this cycle
		logic clear;  // size write: reload size, empty the ring
	} ctl_t;

endpackage
`default_nettype wire

/* sv/cq_if.sv */
`default_nettype none
interface cq_req_if;
	import cq_pkg::*;
	logic  valid;
	logic  ready;
	cmd_t  cmd;
	word_t data_in;

	modport source (output valid, output cmd, output data_in, input ready);
	modport sink (input valid, input cmd, input data_in, output ready);
endinterface

interface cq_rsp_if;
	import cq_pkg::*;
	logic    valid;
	logic    ready;
	word_t   data_out;
	status_t status;

	modport source (output valid, output data_out, output status, input ready);
	modport sink (input valid, input data_out, input status, output ready);
endinterface
`default_nettype wire

/* sv/cq_ctrl.sv */
`default_nettype none
module cq_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire logic        cfg_we,
	output cq_pkg::ctl_t     ctl
);
	import cq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_HOLD = 1'b1;

	logic state_q;
	logic state_d;
	logic take;

	// a new word may enter when nothing is held or the held result leaves now
	assign in_ready  = (state_q == S_IDLE) || out_ready;
	assign take      = in_valid && in_ready;
	assign out_valid = (state_q == S_HOLD);

	assign ctl.take  = take;
	assign ctl.clear = cfg_we;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (take) state_d = S_HOLD;
				else if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

/* sv/cq_dpath.sv */
`default_nettype none
module cq_dpath #(
	parameter int DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cq_pkg::ctl_t     ctl,
	input  wire cq_pkg::cmd_t     cmd,
	input  wire cq_pkg::word_t    data_in,
	input  wire cq_pkg::qsize_t   cfg_data,
	output cq_pkg::word_t         data_out,
	output cq_pkg::status_t       status
);
	import cq_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH + 1);
	localparam int RST_SIZE = (DEPTH < QSIZE_RST) ? DEPTH : QSIZE_RST;

	logic [SW-1:0] size_q;
	logic [SW-1:0] size_d;
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [PW-1:0] head_nx;
	logic [PW-1:0] tail_nx;
	logic [PW-1:0] last;
	logic [PW-1:0] raddr;
	logic [SW-1:0] head_p1;
	logic [SW-1:0] tail_p1;
	logic          full;
	logic          empty;

	// result flags and read data, loaded with each accepted word
	logic          enq_q;
	logic          full_q;
	logic          empty_q;
	word_t         rd_q;

	word_t         mem [DEPTH];

	// clamp the written size to 2..DEPTH
	always_comb begin
		if (cfg_data < qsize_t'(QSIZE_MIN)) size_d = SW'(QSIZE_MIN);
		else if (32'(cfg_data) > 32'(DEPTH)) size_d = SW'(DEPTH);
		else size_d = SW'(cfg_data);
	end

	// wrap increments and the slot of the newest word
	assign head_p1 = SW'(head_q) + SW'(1);
	assign tail_p1 = SW'(tail_q) + SW'(1);
	assign head_nx = (head_p1 >= size_q) ? '0 : head_p1[PW-1:0];
	assign tail_nx = (tail_p1 >= size_q) ? '0 : tail_p1[PW-1:0];
	assign last    = (tail_q == '0) ? PW'(size_q - SW'(1)) : tail_q - PW'(1);

	assign empty = (head_q == tail_q);
	assign full  = (tail_nx == head_q);
	assign raddr = (cmd == CMD_PEEK_REAR) ? last : head_q;

	// size and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SW'(RST_SIZE);
			head_q <= '0;
			tail_q <= '0;
		end else if (ctl.clear) begin
			size_q <= size_d;
			head_q <= '0;
			tail_q <= '0;
		end else if (ctl.take) begin
			case (cmd)
				CMD_ENQ: begin
					if (!full) tail_q <= tail_nx;
				end
				CMD_DEQ: begin
					if (!empty) head_q <= head_nx;
				end
				default: ;
			endcase
		end
	end

	// slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (ctl.take && (cmd == CMD_ENQ) && !full) mem[tail_q] <= data_in;
		if (ctl.take) rd_q <= mem[raddr];
	end

	// result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enq_q   <= 1'b0;
			full_q  <= 1'b0;
			empty_q <= 1'b0;
		end else if (ctl.take) begin
			enq_q   <= (cmd == CMD_ENQ);
			full_q  <= full;
			empty_q <= empty;
		end
	end

	// result word
	always_comb begin
		if (enq_q) begin
			data_out = WORD_ZERO;
			status   = full_q ? ST_FULL : ST_OK;
		end else if (empty_q) begin
			data_out = WORD_NEG_ONE;
			status   = ST_EMPTY;
		end else begin
			data_out = rd_q;
			status   = ST_OK;
		end
	end

endmodule
`default_nettype wire

/* sv/circular_queue_with_peek_top.sv */
// Ring-buffer queue of signed 32-bit words with peek.
// req channel carries a command word (cmd, data_in); rsp channel returns one
// word (data_out, status) per command: enqueue, dequeue, peek front, peek rear.
// cfg_we/cfg_data load the ring size (clamped to 2..DEPTH); a write also
// empties the queue. Write it only while no command is in flight.
// Capacity is ring size minus one, since one slot always stays empty.
// The result is valid in the cycle after the command is accepted.
// Throughput: one command per cycle while rsp.ready stays high; the single
// result register and the registered read port of the slot memory set this.
// When rsp stalls the result holds and req.ready is low until it is taken.
// Reset: queue empty, ring size 16 (or DEPTH if smaller), no result pending.
// Slot memory is not cleared; a slot's word is only returned after it was written.
`default_nettype none
module circular_queue_with_peek_top #(
	parameter int DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	cq_req_if.sink                req,
	cq_rsp_if.source              rsp,
	input  wire logic             cfg_we,
	input  wire cq_pkg::qsize_t   cfg_data
);
	import cq_pkg::*;

	ctl_t ctl;

	cq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cfg_we    (cfg_we),
		.ctl       (ctl)
	);

	cq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cmd      (req.cmd),
		.data_in  (req.data_in),
		.cfg_data (cfg_data),
		.data_out (rsp.data_out),
		.status   (rsp.status)
	);

endmodule
`default_nettype wire

/* sv/cq_checker.sv */
`default_nettype none
module cq_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 req_valid,
	input wire logic                 req_ready,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire cq_pkg::word_t        rsp_data_out,
	input wire cq_pkg::status_t      rsp_status
);
	import cq_pkg::*;

	// a held result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// an accepted command shows its result on the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no result after accepted command");

	// no new command while a result waits untaken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("command accepted over a stalled result");

	// status codes and the empty marker
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL
			|| (rsp_status == ST_EMPTY && rsp_data_out == WORD_NEG_ONE)))
		else $error("bad status or empty word");

	// a dropped enqueue returns zero
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_data_out == WORD_ZERO)
		else $error("full result carries data");

endmodule

bind circular_queue_with_peek_top cq_checker u_cq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_data_out (rsp.data_out),
	.rsp_status   (rsp.status)
);
`default_nettype wire

/* tb/circular_queue_with_peek_top_tb.sv */
`timescale 1ns / 100ps
module circular_queue_with_peek_top_tb;
	import cq_pkg::*;

	localparam int QDEPTH = 16;

	// one reply word as the queue should return it
	typedef struct {
		word_t   data;
		status_t status;
	} queue_reply_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   cfg_we;
	qsize_t cfg_data;

	cq_req_if req_if ();
	cq_rsp_if rsp_if ();

	circular_queue_with_peek_top #(
		.DEPTH(QDEPTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// queue state as the testbench tracks it
	word_t       ring_words [QDEPTH];
	int unsigned ring_head = 0;
	int unsigned ring_tail = 0;
	qsize_t      ring_size = qsize_t'(QSIZE_RST);

	queue_reply_t replies_due[$];
	int           mismatch_count = 0;

	// traffic shaping knobs
	bit gaps_on     = 1'b1;
	bit stalls_on   = 1'b1;
	int burst_left  = 0;
	int hold_cycles = 0;

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
	endfunction

	// applies one command to the tracked ring, returns the reply word
	function automatic queue_reply_t ring_model_cmd(input cmd_t op, input word_t w);
		queue_reply_t r;
		int unsigned  slots_used;
		int unsigned  nxt;
		int unsigned  last;
		slots_used = (ring_size < QSIZE_MIN) ? QSIZE_MIN :
			(ring_size > QDEPTH) ? QDEPTH : ring_size;
		r.data = WORD_ZERO;
		r.status = ST_OK;
		if (op == CMD_ENQ) begin
			nxt = (ring_tail + 1 >= slots_used) ? 0 : ring_tail + 1;
			if (nxt == ring_head) begin
				r.status = ST_FULL;
			end else begin
				ring_words[ring_tail] = w;
				ring_tail = nxt;
			end
		end else if (ring_head == ring_tail) begin
			r.data = WORD_NEG_ONE;
			r.status = ST_EMPTY;
		end else if (op == CMD_DEQ) begin
			r.data = ring_words[ring_head];
			ring_head = (ring_head + 1 >= slots_used) ? 0 : ring_head + 1;
		end else if (op == CMD_PEEK_FRONT) begin
			r.data = ring_words[ring_head];
		end else begin
			// newest word sits just behind the tail, wrapping at the ring end
			last = (ring_tail == 0) ? slots_used - 1 : ring_tail - 1;
			r.data = ring_words[last];
		end
		return r;
	endfunction

	// check replies, track size writes, predict accepted commands
	always @(posedge clk) begin : scoreboard
		queue_reply_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (replies_due.size() == 0) begin
					note_mismatch($sformatf("unexpected reply: data_out %0d status %0d",
						rsp_if.data_out, rsp_if.status));
				end else begin
					want = replies_due.pop_front();
					if (rsp_if.data_out !== want.data) begin
						note_mismatch($sformatf("data_out: expected %0d, got %0d",
							want.data, rsp_if.data_out));
					end
					if (rsp_if.status !== want.status) begin
						note_mismatch($sformatf("status: expected %0d, got %0d",
							want.status, rsp_if.status));
					end
				end
			end
			// a size write empties the ring
			if (cfg_we) begin
				ring_size = cfg_data;
				ring_head = 0;
				ring_tail = 0;
			end
			if (req_if.valid && req_if.ready) begin
				replies_due.push_back(ring_model_cmd(req_if.cmd, req_if.data_in));
			end
		end
	end

	// reply side: long hold-off when asked, otherwise a rotating stall pattern
	always @(negedge clk) begin : reply_taker
		logic [15:0] stall_pat;
		int          pat_left;
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			rsp_if.ready <= 1'b0;
		end else begin
			if (pat_left <= 0) begin
				pat_left = 16;
				case ($urandom_range(0, 3))
					0: stall_pat = '1;
					1: stall_pat = 16'(($urandom() | $urandom()));
					default: stall_pat = 16'($urandom());
				endcase
			end
			rsp_if.ready <= stalls_on ? stall_pat[0] : 1'b1;
			stall_pat = {stall_pat[0], stall_pat[15:1]};
			pat_left = pat_left - 1;
		end
	end

	// offer one command word; returns at the edge where it is taken
	task automatic send_cmd(input cmd_t op, input word_t w);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap != 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.cmd <= op;
		req_if.data_in <= w;
		do @(posedge clk); while (!req_if.ready);
	endtask

	// stop offering and wait for every reply still due
	task automatic drain_replies();
		@(negedge clk);
		req_if.valid <= 1'b0;
		for (int n = 0; n < 4000 && replies_due.size() != 0; n++) @(posedge clk);
		repeat (3) @(posedge clk);
		if (replies_due.size() != 0) begin
			note_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
			replies_due.delete();
		end
	endtask

	task automatic set_ring_size(input qsize_t n);
		drain_replies();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= n;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic word_t pick_word();
		case ($urandom_range(0, 11))
			0: return word_t'(32'h8000_0000);
			1: return word_t'(32'h7fff_ffff);
			2: return WORD_NEG_ONE;
			3: return WORD_ZERO;
			default: return word_t'($urandom());
		endcase
	endfunction

	function automatic cmd_t pick_cmd(input int enq_pct);
		if ($urandom_range(0, 99) < enq_pct) begin
			return CMD_ENQ;
		end
		case ($urandom_range(0, 3))
			0, 1: return CMD_DEQ;
			2: return CMD_PEEK_FRONT;
			default: return CMD_PEEK_REAR;
		endcase
	endfunction

	// every non-enqueue on an empty queue; data_in must be ignored
	task automatic test_empty_queue();
		send_cmd(CMD_DEQ, word_t'(32'h1234_5678));
		send_cmd(CMD_PEEK_FRONT, WORD_NEG_ONE);
		send_cmd(CMD_PEEK_REAR, word_t'(32'h8000_0000));
	endtask

	// extreme words through the default 16-slot ring
	task automatic test_extreme_words();
		send_cmd(CMD_ENQ, word_t'(32'h8000_0000));
		send_cmd(CMD_ENQ, word_t'(32'h7fff_ffff));
		send_cmd(CMD_ENQ, WORD_NEG_ONE);
		send_cmd(CMD_ENQ, WORD_ZERO);
		send_cmd(CMD_PEEK_FRONT, WORD_ZERO);
		send_cmd(CMD_PEEK_REAR, WORD_ZERO);
		repeat (4) send_cmd(CMD_DEQ, word_t'($urandom()));
		send_cmd(CMD_DEQ, WORD_ZERO);
	endtask

	// smallest ring: full on one word, tail wrap, sizes below the minimum
	task automatic test_small_rings();
		set_ring_size(qsize_t'(2));
		send_cmd(CMD_ENQ, word_t'(32'h0bad_cafe));
		send_cmd(CMD_ENQ, word_t'(32'h7654_3210));
		send_cmd(CMD_DEQ, WORD_ZERO);
		send_cmd(CMD_ENQ, word_t'(32'hfeed_0001));
		send_cmd(CMD_PEEK_REAR, WORD_ZERO);
		send_cmd(CMD_PEEK_FRONT, WORD_ZERO);
		set_ring_size(qsize_t'(0));
		send_cmd(CMD_ENQ, word_t'(32'h5555_aaaa));
		send_cmd(CMD_ENQ, word_t'(32'haaaa_5555));
	endtask

	// random commands over several ring sizes, fill-heavy and drain-heavy runs
	task automatic test_random_traffic();
		qsize_t sizes [8] = '{5'd31, 5'd3, 5'd1, 5'd16, 5'd9, 5'd17, 5'd2, 5'd0};
		int     enq_pct;
		foreach (sizes[p]) begin
			gaps_on = (p % 3 != 1);
			stalls_on = (p % 3 != 2);
			set_ring_size((p == 7) ? qsize_t'($urandom_range(0, 31)) : sizes[p]);
			for (int k = 0; k < 115; k++) begin
				if (k % 20 == 0) begin
					case ($urandom_range(0, 2))
						0: enq_pct = 15;
						1: enq_pct = 50;
						default: enq_pct = 85;
					endcase
				end
				send_cmd(pick_cmd(enq_pct), pick_word());
			end
		end
	endtask

	// reply side holds off while commands keep coming, so the input stalls
	task automatic test_output_backpressure();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		set_ring_size(qsize_t'(QDEPTH));
		@(posedge clk);
		hold_cycles = 60;
		for (int k = 0; k < 40; k++) begin
			send_cmd((k < 28) ? CMD_ENQ : pick_cmd(20), pick_word());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_ENQ;
		req_if.data_in = WORD_ZERO;
		rsp_if.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_extreme_words();
		test_small_rings();
		test_random_traffic();
		test_output_backpressure();
		drain_replies();

		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* circular_queue_with_peek_top.f */
sv/cq_pkg.sv
sv/cq_if.sv
sv/cq_ctrl.sv
sv/cq_dpath.sv
sv/circular_queue_with_peek_top.sv
sv/cq_checker.sv
tb/circular_queue_with_peek_top_tb.sv
